### sv/crc16p_pkg.sv
package crc16p_pkg;

	localparam int CrcW    = 16;
	localparam int DataW   = 8;
	localparam int MaxBits = 8;
	localparam int CntW    = $clog2(MaxBits + 1);

	localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
	localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;

endpackage

### sv/crc16_ccitt_partial_byte_check.sv
// crc-16/ccitt-false engine over partial bytes, msb first, poly 0x1021, init 0xffff.
// input stream (s_axis_*): one transaction per item. tdata[7:0] is the data byte,
// tdata[11:8] the number of bits to take from bit 7 down (above 8 counts as 8,
// 0 absorbs nothing), tdata[15:12] unused. tuser marks the first item of a message
// and reloads the crc with 0xffff, tlast marks the final item.
// output stream (m_axis_*): one transaction per input item. tdata is the running
// crc after the item, tlast echoes the input tlast, tuser is the check error:
// set on a last item whose residue is nonzero.
// a single shift-and-xor step unit is reused once per bit, so an item is accepted
// in the idle state, stepped once per bit in the run state, then loaded into the
// output register from the done state; no new item is taken before that.
// s_axis_tready is high only while the engine is idle. the output register lets
// the engine take the next item while a result waits; when the receiver stalls,
// the engine holds its finished result until the output register frees up.
// reset empties the output register, leaves the engine idle and ready, and sets
// the crc to 0xffff.
module crc16_ccitt_partial_byte_check
	import crc16p_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte[7:0], bit_count[11:8], zero fill
	input  logic        s_axis_tuser,  // first_item
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // crc_value[15:0]
	output logic        m_axis_tuser,  // check_error
	output logic        m_axis_tlast
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t           state_q;
	logic [CrcW-1:0]  crc_q;
	logic [CrcW-1:0]  crc_step;
	logic [DataW-1:0] data_q;
	logic [CntW-1:0]  cnt_q;
	logic             last_q;
	logic             out_valid_q;
	logic [CrcW-1:0]  out_crc_q;
	logic             out_err_q;
	logic             out_last_q;

	logic             in_acc;
	logic             out_free;
	logic [DataW-1:0] in_data;
	logic [CntW-1:0]  in_cnt;
	logic [CntW-1:0]  in_cnt_sat;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign in_data    = s_axis_tdata[DataW-1:0];
	assign in_cnt     = s_axis_tdata[DataW +: CntW];
	assign in_cnt_sat = (in_cnt > CntW'(MaxBits)) ? CntW'(MaxBits) : in_cnt;

	crc16p_bit_step u_step (
		.crc_in  (crc_q),
		.din     (data_q[DataW-1]),
		.crc_out (crc_step)
	);

	// sequencer and crc state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			crc_q   <= CrcInit;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser) begin
							crc_q <= CrcInit;
						end
						cnt_q   <= in_cnt_sat;
						state_q <= (in_cnt_sat == '0) ? S_DONE : S_RUN;
					end
				end
				S_RUN: begin
					crc_q <= crc_step;
					cnt_q <= cnt_q - CntW'(1);
					if (cnt_q == CntW'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_q <= in_data;
			last_q <= s_axis_tlast;
		end else if (state_q == S_RUN) begin
			data_q <= {data_q[DataW-2:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_crc_q  <= crc_q;
			out_err_q  <= last_q && (crc_q != '0);
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_crc_q;
	assign m_axis_tuser  = out_err_q;
	assign m_axis_tlast  = out_last_q;

	a_run_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (cnt_q != '0))
		else $error("step sequencer running with no bits left");

	a_first_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tuser) |=> (crc_q == CrcInit))
		else $error("first item did not reload crc");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result loaded outside done state");

	a_err_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> out_last_q)
		else $error("check error on an item that is not last");

endmodule

### sv/crc16p_bit_step.sv
module crc16p_bit_step
	import crc16p_pkg::*;
(
	input  logic [CrcW-1:0] crc_in,
	input  logic            din,
	output logic [CrcW-1:0] crc_out
);

	logic [CrcW-1:0] shifted;

	assign shifted = {crc_in[CrcW-2:0], 1'b0};

	// feedback is the outgoing msb against the incoming data bit
	assign crc_out = (din ^ crc_in[CrcW-1]) ? (shifted ^ CrcPoly) : shifted;

endmodule

### dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import crc16p_pkg::*;

	localparam int RandomItems = 800;
	localparam int CycleLimit  = 300000;
	localparam int DrainCycles = 24;

	typedef struct packed {
		logic [CrcW-1:0] crc;
		logic            err;
		logic            last;
	} crc_result_t;

	// running crc prediction and the queue of results still to come out
	class crc_tracker;
		logic [CrcW-1:0] crc_reg;
		crc_result_t     expected_q[$];
		int              mismatches;
		int              results_seen;
		int              errors_flagged;

		function new();
			crc_reg = CrcInit;
			mismatches = 0;
			results_seen = 0;
			errors_flagged = 0;
		endfunction

		static function logic [CrcW-1:0] shift_in(logic [CrcW-1:0] crc, logic [DataW-1:0] data,
			logic [CntW-1:0] count);
			int  n;
			logic fb;
			n = (count > MaxBits) ? MaxBits : count;
			for (int k = 0; k < n; k++) begin
				fb = crc[CrcW-1] ^ data[DataW-1-k];
				crc = {crc[CrcW-2:0], 1'b0};
				if (fb)
					crc = crc ^ CrcPoly;
			end
			return crc;
		endfunction

		function void note_item(logic [DataW-1:0] data, logic [CntW-1:0] count, logic first,
			logic last);
			crc_result_t r;
			if (first)
				crc_reg = CrcInit;
			crc_reg = shift_in(crc_reg, data, count);
			r.crc = crc_reg;
			r.err = last && (crc_reg != '0);
			r.last = last;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [CrcW-1:0] crc, logic err, logic last);
			crc_result_t e;
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("unexpected transaction: crc_value %h check_error %b last_out %b",
					crc, err, last);
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			if (e.err)
				errors_flagged++;
			if (crc !== e.crc) begin
				$error("crc_value: expected %h, actual %h", e.crc, crc);
				mismatches++;
			end
			if (err !== e.err) begin
				$error("check_error: expected %b, actual %b", e.err, err);
				mismatches++;
			end
			if (last !== e.last) begin
				$error("last_out: expected %b, actual %b", e.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // data_byte[7:0], bit_count[11:8], zero fill
	logic        s_axis_tuser;  // first_item
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;  // crc_value[15:0]
	logic        m_axis_tuser;  // check_error
	logic        m_axis_tlast;

	crc16_ccitt_partial_byte_check DUT (.*);

	crc_tracker      tracker;
	logic [CrcW-1:0] gen_crc;
	int              items_sent;
	int              msgs_closed;
	int              burst_left;
	int              cycles;
	logic [15:0]     ready_pat;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: rotating ready pattern, reloaded from a random choice of patterns
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAILED: results differ");
			$finish;
		end else if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (cycles % 128 == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pat = 16'hFFFF;
					1: ready_pat = 16'($urandom);
					2: ready_pat = 16'($urandom & $urandom & $urandom);
					default: ready_pat = 16'($urandom | $urandom);
				endcase
				if (ready_pat == '0)
					ready_pat = 16'h0001;
			end
			ready_pat = {ready_pat[14:0], ready_pat[15]};
			m_axis_tready <= ready_pat[0];
		end
	end

	task automatic push_item(input logic [DataW-1:0] data, input logic [CntW-1:0] count,
		input logic first, input logic last);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(16-DataW-CntW){1'b0}}, count, data};
		s_axis_tuser <= first;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_item(data, count, first, last);
		if (first)
			gen_crc = CrcInit;
		gen_crc = crc_tracker::shift_in(gen_crc, data, count);
		items_sent++;
		if (last)
			msgs_closed++;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) :
				$urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	task automatic run_directed();
		int counts[10] = '{0, 1, 2, 3, 5, 7, 8, 9, 12, 15};
		// "123456789" closed without its crc, then the crc bytes continue with no reload
		for (int i = 0; i < 9; i++)
			push_item(8'(8'h31 + i), 4'd8, i == 0, i == 8);
		push_item(8'h29, 4'd8, 1'b0, 1'b0);
		push_item(8'hB1, 4'd8, 1'b0, 1'b1);
		// zero count, several partial counts, saturation above eight, first and last together
		for (int k = 0; k < 10; k++)
			push_item((k % 2) ? 8'hFF : 8'h00, CntW'(counts[k]), k == 0 || k == 3,
				k == 3 || k == 9);
	endtask

	// message closed by its own crc, split into random bit chunks, sometimes corrupted
	task automatic send_framed_message();
		int              body;
		int              left;
		int              n;
		logic [CntW-1:0] c;
		logic [7:0]      mask;
		logic [7:0]      d;
		logic [CrcW-1:0] tail;
		body = $urandom_range(1, 10);
		for (int i = 0; i < body; i++) begin
			case ($urandom_range(0, 15))
				0: c = '0;
				1: c = CntW'($urandom_range(9, 15));
				2, 3, 4, 5: c = CntW'($urandom_range(1, 8));
				default: c = CntW'(MaxBits);
			endcase
			push_item(8'($urandom), c, i == 0, 1'b0);
		end
		tail = gen_crc;
		if ($urandom_range(0, 4) == 0)
			tail = tail ^ (16'h0001 << $urandom_range(0, 15));
		left = 16;
		while (left > 0) begin
			n = $urandom_range(0, 1) ? ((left > 8) ? 8 : left) :
				$urandom_range(1, (left > 8) ? 8 : left);
			mask = 8'hFF << (8 - n);
			d = (tail[15:8] & mask) | (8'($urandom) & ~mask);
			tail = tail << n;
			left -= n;
			push_item(d, CntW'(n), 1'b0, left == 0);
		end
	endtask

	task automatic send_noise();
		int len;
		len = $urandom_range(1, 6);
		repeat (len)
			push_item(8'($urandom), CntW'($urandom_range(0, 15)), $urandom_range(0, 3) == 0,
				$urandom_range(0, 3) == 0);
	endtask

	initial begin
		int target;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		ready_pat = 16'hFFFF;
		tracker = new();
		gen_crc = CrcInit;
		items_sent = 0;
		msgs_closed = 0;
		burst_left = 8;
		cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		target = items_sent + RandomItems;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) < 7)
				send_framed_message();
			else
				send_noise();
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.expected_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d items, %0d closed messages, %0d results compared",
			items_sent, msgs_closed, tracker.results_seen);
		$display("partial counts, saturated counts and crc tails; %0d messages failed the check",
			tracker.errors_flagged);
		if (tracker.mismatches == 0 && tracker.expected_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### crc16_ccitt_partial_byte_check.f
sv/crc16p_pkg.sv
sv/crc16p_bit_step.sv
sv/crc16_ccitt_partial_byte_check.sv
dv/testbench.sv
